@@ rtl/sadr_pkg.sv @@
// Package: shared types, register codes and constants of the audio/data register device.
`default_nettype none

package sadr_pkg;

   // Revision digit shown in the status byte and the ID text
   localparam logic [2:0]  REVISION    = 3'd1;
   // Audio header length skipped on track open and rewind
   localparam logic [31:0] HEADER_SKIP = 32'd58;
   localparam logic [31:0] SAMPLE_BYTES = 32'd4;

   // Transfer kinds
   localparam logic [1:0] MODE_BUS_READ = 2'd0;
   localparam logic [1:0] MODE_WRITE    = 2'd1;
   localparam logic [1:0] MODE_TICK     = 2'd2;

   // Register offsets
   localparam logic [2:0] REG_STATUS    = 3'd0;
   localparam logic [2:0] REG_DATA_PORT = 3'd1;
   localparam logic [2:0] REG_DATA_OFF0 = 3'd0;
   localparam logic [2:0] REG_DATA_OFF1 = 3'd1;
   localparam logic [2:0] REG_DATA_OFF2 = 3'd2;
   localparam logic [2:0] REG_DATA_OFF3 = 3'd3;
   localparam logic [2:0] REG_TRACK_LO  = 3'd4;
   localparam logic [2:0] REG_TRACK_HI  = 3'd5;
   localparam logic [2:0] REG_VOLUME    = 3'd6;
   localparam logic [2:0] REG_CONTROL   = 3'd7;

   localparam logic [7:0] VOLUME_RESET = 8'd255;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         reg_index;
      logic [7:0]         write_data;
      logic               data_file_present;
      logic [7:0]         data_byte_in;
      logic               track_opened;
      logic               track_at_end;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [31:0]        data_position;
      logic               data_seek;
      logic               data_advance;
      logic [15:0]        track_number;
      logic               track_load;
      logic [31:0]        audio_position;
      logic               sample_taken;
      logic               audio_rewind;
   } rsp_payload_type;

   // Input stage to engine
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_type;

   // ID text for read offsets 2..7: five ID characters, then the revision digit
   function automatic logic [7:0] id_char(input logic [2:0] idx);
      logic [7:0] c;
      begin
         case (idx)
            3'd2:    c = 8'h53;
            3'd3:    c = 8'h2d;
            3'd4:    c = 8'h4d;
            3'd5:    c = 8'h53;
            3'd6:    c = 8'h55;
            default: c = 8'h30 + {5'd0, REVISION};
         endcase
         return c;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/sadr_req_if.sv @@
// Interface: request channel carrying one bus access or audio tick per transfer.
`default_nettype none

interface sadr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [2:0]         reg_index;
   logic [7:0]         write_data;
   logic               data_file_present;
   logic [7:0]         data_byte_in;
   logic               track_opened;
   logic               track_at_end;
   logic signed [15:0] left_in;
   logic signed [15:0] right_in;

   modport source (output valid, mode, reg_index, write_data, data_file_present,
                   data_byte_in, track_opened, track_at_end, left_in, right_in,
                   input ready);
   modport sink   (input valid, mode, reg_index, write_data, data_file_present,
                   data_byte_in, track_opened, track_at_end, left_in, right_in,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/sadr_rsp_if.sv @@
// Interface: response channel carrying one result per transfer.
`default_nettype none

interface sadr_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         read_data;
   logic signed [15:0] left_out;
   logic signed [15:0] right_out;
   logic [31:0]        data_position;
   logic               data_seek;
   logic               data_advance;
   logic [15:0]        track_number;
   logic               track_load;
   logic [31:0]        audio_position;
   logic               sample_taken;
   logic               audio_rewind;

   modport source (output valid, read_data, left_out, right_out, data_position,
                   data_seek, data_advance, track_number, track_load,
                   audio_position, sample_taken, audio_rewind,
                   input ready);
   modport sink   (input valid, read_data, left_out, right_out, data_position,
                   data_seek, data_advance, track_number, track_load,
                   audio_position, sample_taken, audio_rewind,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/sadr_scale.sv @@
// Volume scaler: sample * volume / 255, truncated toward zero.
`default_nettype none

module sadr_scale (
   input  wire logic signed [15:0] sample,
   input  wire logic [7:0]         volume,
   output logic signed [15:0]      scaled
);

   logic [16:0] ext;
   logic [16:0] mag;
   logic [24:0] prod;
   logic [22:0] x;
   logic [23:0] approx;
   logic [15:0] q0;
   logic [23:0] q0_times;
   logic [23:0] rem;
   logic [15:0] q;

   // Work on the magnitude so the quotient truncates toward zero
   assign ext  = {sample[15], sample};
   assign mag  = sample[15] ? (~ext + 17'd1) : ext;
   assign prod = 25'(mag) * 25'(volume);
   assign x    = prod[22:0];

   // x/255 ~ (x + x/256 + x/65536) / 256, low by at most one
   assign approx   = 24'(x) + 24'(x >> 8) + 24'(x >> 16);
   assign q0       = approx[23:8];
   assign q0_times = {q0, 8'd0} - 24'(q0);
   assign rem      = 24'(x) - q0_times;
   assign q        = (rem >= 24'd255) ? (q0 + 16'd1) : q0;

   // Restore the sign
   assign scaled = sample[15] ? $signed(~q + 16'd1) : $signed(q);

endmodule

`default_nettype wire

@@ rtl/sadr_in_stage.sv @@
// Input register: captures one request transfer and holds it until the engine takes it.
`default_nettype none

module sadr_in_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire sadr_pkg::req_payload_type req_payload,
   input  wire logic                     advance,
   output sadr_pkg::stage_type           stage
);

   logic                      valid_ff;
   logic                      valid_in;
   sadr_pkg::req_payload_type payload_ff;

   // Accept when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload unless a new transfer lands
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         payload_ff <= req_payload;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = payload_ff;

endmodule

`default_nettype wire

@@ rtl/sadr_engine.sv @@
// Engine: device state, per-item update and the response register.
`default_nettype none

module sadr_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sadr_pkg::stage_type stage,
   output logic                     advance,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sadr_pkg::rsp_payload_type rsp_payload
);

   // Device state
   logic [31:0] data_off_ff,  data_off_in;
   logic [31:0] audio_off_ff, audio_off_in;
   logic [15:0] track_ff,     track_in;
   logic [7:0]  volume_ff,    volume_in;
   logic        data_busy_ff, data_busy_in;
   logic        audio_busy_ff, audio_busy_in;
   logic        repeat_ff,    repeat_in;
   logic        play_ff,      play_in;
   logic        track_open_ff, track_open_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   sadr_pkg::rsp_payload_type rsp_ff, rsp_in;

   sadr_pkg::req_payload_type p;
   logic               take;
   logic signed [15:0] left_scaled;
   logic signed [15:0] right_scaled;

   assign p = stage.payload;

   // Move the held item into the response register when it is free
   assign advance = stage.valid && (!rsp_valid_ff || rsp_ready);

   sadr_scale u_scale_left (
      .sample (p.left_in),
      .volume (volume_ff),
      .scaled (left_scaled)
   );

   sadr_scale u_scale_right (
      .sample (p.right_in),
      .volume (volume_ff),
      .scaled (right_scaled)
   );

   // Work out next state and the result of the held item
   always_comb begin
      data_off_in   = data_off_ff;
      audio_off_in  = audio_off_ff;
      track_in      = track_ff;
      volume_in     = volume_ff;
      data_busy_in  = data_busy_ff;
      audio_busy_in = audio_busy_ff;
      repeat_in     = repeat_ff;
      play_in       = play_ff;
      track_open_in = track_open_ff;
      take          = 1'b0;
      rsp_in        = '0;

      unique case (p.mode)
         sadr_pkg::MODE_BUS_READ: begin
            unique case (p.reg_index)
               sadr_pkg::REG_STATUS: begin
                  rsp_in.read_data = {data_busy_ff, audio_busy_ff, repeat_ff, play_ff,
                                      1'b0, sadr_pkg::REVISION};
               end
               sadr_pkg::REG_DATA_PORT: begin
                  if (!data_busy_ff) begin
                     data_off_in = data_off_ff + 32'd1;
                     if (p.data_file_present) begin
                        rsp_in.data_advance = 1'b1;
                        rsp_in.read_data    = p.data_byte_in;
                     end
                  end
               end
               default: begin
                  rsp_in.read_data = sadr_pkg::id_char(p.reg_index);
               end
            endcase
         end
         sadr_pkg::MODE_WRITE: begin
            unique case (p.reg_index)
               sadr_pkg::REG_DATA_OFF0: data_off_in[7:0]   = p.write_data;
               sadr_pkg::REG_DATA_OFF1: data_off_in[15:8]  = p.write_data;
               sadr_pkg::REG_DATA_OFF2: data_off_in[23:16] = p.write_data;
               sadr_pkg::REG_DATA_OFF3: begin
                  data_off_in[31:24] = p.write_data;
                  rsp_in.data_seek   = p.data_file_present;
                  data_busy_in       = 1'b0;
               end
               sadr_pkg::REG_TRACK_LO: track_in[7:0] = p.write_data;
               sadr_pkg::REG_TRACK_HI: begin
                  track_in[15:8]    = p.write_data;
                  rsp_in.track_load = 1'b1;
                  track_open_in     = p.track_opened;
                  if (p.track_opened) begin
                     audio_off_in = sadr_pkg::HEADER_SKIP;
                  end
                  audio_busy_in = 1'b0;
                  repeat_in     = 1'b0;
                  play_in       = 1'b0;
               end
               sadr_pkg::REG_VOLUME: volume_in = p.write_data;
               default: begin
                  repeat_in = p.write_data[1];
                  play_in   = p.write_data[0];
               end
            endcase
         end
         sadr_pkg::MODE_TICK: begin
            if (play_ff) begin
               if (!track_open_ff) begin
                  play_in = 1'b0;
               end else if (p.track_at_end) begin
                  // Rewind past the header; stop unless repeating
                  if (!repeat_ff) begin
                     play_in = 1'b0;
                  end
                  audio_off_in        = sadr_pkg::HEADER_SKIP;
                  rsp_in.audio_rewind = 1'b1;
               end else begin
                  audio_off_in        = audio_off_ff + sadr_pkg::SAMPLE_BYTES;
                  rsp_in.sample_taken = 1'b1;
                  take                = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (take) begin
         rsp_in.left_out  = left_scaled;
         rsp_in.right_out = right_scaled;
      end
      rsp_in.data_position  = data_off_in;
      rsp_in.track_number   = track_in;
      rsp_in.audio_position = audio_off_in;
   end

   // Drop the response once taken, load a new one on advance
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_off_ff   <= '0;
         audio_off_ff  <= '0;
         track_ff      <= '0;
         volume_ff     <= sadr_pkg::VOLUME_RESET;
         data_busy_ff  <= 1'b1;
         audio_busy_ff <= 1'b1;
         repeat_ff     <= 1'b0;
         play_ff       <= 1'b0;
         track_open_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            data_off_ff   <= data_off_in;
            audio_off_ff  <= audio_off_in;
            track_ff      <= track_in;
            volume_ff     <= volume_in;
            data_busy_ff  <= data_busy_in;
            audio_busy_ff <= audio_busy_in;
            repeat_ff     <= repeat_in;
            play_ff       <= play_in;
            track_open_ff <= track_open_in;
         end
      end
   end

   // Hold the result until the next item advances
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/streamed_audio_data_register_device_top.sv @@
// Top level: audio/data streaming register device with request and response channels.
// Path: a request transfer passes the input register, then the response register,
// to give its response; the update and volume scaling fit between the two.
// Throughput: one transfer per cycle while the response channel is not stalled.
// Reset: synchronous, active high; clears both channels, offsets, track and flags,
// sets volume to 255 and both busy flags.
`default_nettype none

module streamed_audio_data_register_device_top (
   input wire logic clock,
   input wire logic reset,
   sadr_req_if.sink   req_ch,
   sadr_rsp_if.source rsp_ch
);

   sadr_pkg::req_payload_type req_payload;
   sadr_pkg::rsp_payload_type rsp_payload;
   sadr_pkg::stage_type       stage;
   logic                      advance;

   assign req_payload.mode              = req_ch.mode;
   assign req_payload.reg_index         = req_ch.reg_index;
   assign req_payload.write_data        = req_ch.write_data;
   assign req_payload.data_file_present = req_ch.data_file_present;
   assign req_payload.data_byte_in      = req_ch.data_byte_in;
   assign req_payload.track_opened      = req_ch.track_opened;
   assign req_payload.track_at_end      = req_ch.track_at_end;
   assign req_payload.left_in           = req_ch.left_in;
   assign req_payload.right_in          = req_ch.right_in;

   sadr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_payload),
      .advance     (advance),
      .stage       (stage)
   );

   sadr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .advance     (advance),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_ch.read_data      = rsp_payload.read_data;
   assign rsp_ch.left_out       = rsp_payload.left_out;
   assign rsp_ch.right_out      = rsp_payload.right_out;
   assign rsp_ch.data_position  = rsp_payload.data_position;
   assign rsp_ch.data_seek      = rsp_payload.data_seek;
   assign rsp_ch.data_advance   = rsp_payload.data_advance;
   assign rsp_ch.track_number   = rsp_payload.track_number;
   assign rsp_ch.track_load     = rsp_payload.track_load;
   assign rsp_ch.audio_position = rsp_payload.audio_position;
   assign rsp_ch.sample_taken   = rsp_payload.sample_taken;
   assign rsp_ch.audio_rewind   = rsp_payload.audio_rewind;

endmodule

`default_nettype wire

@@ rtl/sadr_checker.sv @@
// Checker: port-level properties of the device, bound to the top level.
`default_nettype none

module sadr_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [7:0]         read_data,
   input wire logic signed [15:0] left_out,
   input wire logic signed [15:0] right_out,
   input wire logic [31:0]        data_position,
   input wire logic               data_seek,
   input wire logic               data_advance,
   input wire logic               track_load,
   input wire logic               sample_taken,
   input wire logic               audio_rewind
);

   // Both channels come out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("channels not empty after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(data_position)
                                     && $stable(read_data) && $stable(left_out)))
      else $error("stalled response changed");

   // At most one kind of side effect per response
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({data_seek, data_advance, track_load,
                                sample_taken, audio_rewind}) <= 1)
      else $error("more than one action flag in a response");

   // Samples appear only with a consumed pair, never with a read byte
   a_samples_only_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !sample_taken) |-> (left_out == 16'sd0 && right_out == 16'sd0))
      else $error("samples without a consumed pair");

endmodule

bind streamed_audio_data_register_device_top sadr_checker u_sadr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .read_data     (rsp_ch.read_data),
   .left_out      (rsp_ch.left_out),
   .right_out     (rsp_ch.right_out),
   .data_position (rsp_ch.data_position),
   .data_seek     (rsp_ch.data_seek),
   .data_advance  (rsp_ch.data_advance),
   .track_load    (rsp_ch.track_load),
   .sample_taken  (rsp_ch.sample_taken),
   .audio_rewind  (rsp_ch.audio_rewind)
);

`default_nettype wire
